// ===== src/rgbhsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, sector codes and stage records for the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned QUO_W    = 16;
  localparam int unsigned HDIV_W   = CHAN_W + 3;
  localparam int unsigned SDIV_W   = CHAN_W + QUO_W;
  localparam int unsigned FRONT_STAGES = 3;
  localparam int unsigned LATENCY  = FRONT_STAGES + QUO_W + 1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [HDIV_W-1:0] hdiv_t;
  typedef logic [SDIV_W-1:0] sdiv_t;
  typedef logic [QUO_W-1:0]  quo_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // One long-division lane: partial remainder, divisor, pending dividend bits,
  // quotient built so far.
  typedef struct packed {
    chan_t rem;
    chan_t div;
    quo_t  low;
    quo_t  quo;
  } sat_lane_t;

  typedef struct packed {
    hdiv_t rem;
    hdiv_t div;
    quo_t  quo;
  } hue_lane_t;

endpackage

// ===== src/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// Fully pipelined 8-bit RGB to 16-bit HSV conversion.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge with start high and busy low; busy is
// high only while rst_n is asserted.
// Each result appears on the out_ ports for one cycle with out_valid high,
// in input order. The receiver cannot stall, so results must be captured
// when out_valid is high. The pipeline holds three front stages (max/min,
// delta and hue numerator, divisor setup), sixteen restoring-division
// stages that produce one quotient bit each for hue and saturation in
// parallel, and one output register. Throughput is one pixel per clock
// while busy is low.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top
  import rgbhsv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  output logic             out_valid,
  output logic [15:0]      out_hue,
  output logic [15:0]      out_saturation,
  output logic [15:0]      out_brightness,
  output logic             out_hue_undefined
);

  logic accept;
  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Stage 1: max, min, sector
  logic    s1_valid_r;
  chan_t   s1_red_r, s1_green_r, s1_blue_r, s1_max_r, s1_min_r;
  sector_t s1_sector_r;
  chan_t   s1_max_nxt, s1_min_nxt, rg_max, rg_min;
  sector_t s1_sector_nxt;

  always_comb begin
    rg_max     = (in_red > in_green) ? in_red : in_green;
    rg_min     = (in_red < in_green) ? in_red : in_green;
    s1_max_nxt = (in_blue > rg_max) ? in_blue : rg_max;
    s1_min_nxt = (in_blue < rg_min) ? in_blue : rg_min;
    priority if (in_red >= s1_max_nxt) begin
      s1_sector_nxt = SEC_RED;
    end else if (in_green >= s1_max_nxt) begin
      s1_sector_nxt = SEC_GREEN;
    end else begin
      s1_sector_nxt = SEC_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    s1_red_r    <= in_red;
    s1_green_r  <= in_green;
    s1_blue_r   <= in_blue;
    s1_max_r    <= s1_max_nxt;
    s1_min_r    <= s1_min_nxt;
    s1_sector_r <= s1_sector_nxt;
  end

  // Stage 2: delta and hue numerator
  logic  s2_valid_r;
  chan_t s2_max_r, s2_delta_r;
  hdiv_t s2_num_r;
  chan_t s2_delta_nxt;
  hdiv_t s2_num_nxt, six_delta;
  logic [CHAN_W:0] diff;

  always_comb begin
    s2_delta_nxt = s1_max_r - s1_min_r;
    six_delta    = (HDIV_W'(s2_delta_nxt) << 2) + (HDIV_W'(s2_delta_nxt) << 1);
    diff         = '0;
    unique case (s1_sector_r)
      SEC_RED: begin
        diff       = {1'b0, s1_green_r} - {1'b0, s1_blue_r};
        s2_num_nxt = {{(HDIV_W-CHAN_W-1){diff[CHAN_W]}}, diff};
        if (diff[CHAN_W]) begin
          s2_num_nxt = s2_num_nxt + six_delta;
        end
      end
      SEC_GREEN: begin
        s2_num_nxt = (HDIV_W'(s2_delta_nxt) << 1) + HDIV_W'(s1_blue_r)
                     - HDIV_W'(s1_red_r);
      end
      SEC_BLUE: begin
        s2_num_nxt = (HDIV_W'(s2_delta_nxt) << 2) + HDIV_W'(s1_red_r)
                     - HDIV_W'(s1_green_r);
      end
      default: begin
        s2_num_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_max_r   <= s1_max_r;
    s2_delta_r <= s2_delta_nxt;
    s2_num_r   <= s2_num_nxt;
  end

  // Stage 3 and division stages: index 0 is the divider input
  logic      dv_valid_r [0:QUO_W];
  chan_t     dv_max_r   [0:QUO_W];
  sat_lane_t sat_r      [0:QUO_W];
  hue_lane_t hue_r      [0:QUO_W];
  sat_lane_t sat_nxt    [0:QUO_W];
  hue_lane_t hue_nxt    [0:QUO_W];
  sdiv_t     sat_dividend;
  logic [CHAN_W:0] s_trial [0:QUO_W-1];
  logic [HDIV_W:0] h_trial [0:QUO_W-1];

  always_comb begin
    sat_dividend = {s2_delta_r, QUO_W'(0)} - SDIV_W'(s2_delta_r);
    sat_nxt[0].rem = sat_dividend[SDIV_W-1:QUO_W];
    sat_nxt[0].div = s2_max_r;
    sat_nxt[0].low = sat_dividend[QUO_W-1:0];
    sat_nxt[0].quo = '0;
    hue_nxt[0].rem = s2_num_r;
    hue_nxt[0].div = (HDIV_W'(s2_delta_r) << 2) + (HDIV_W'(s2_delta_r) << 1);
    hue_nxt[0].quo = '0;
    for (int k = 0; k < QUO_W; k++) begin
      s_trial[k] = {sat_r[k].rem, sat_r[k].low[QUO_W-1]};
      sat_nxt[k+1].div = sat_r[k].div;
      sat_nxt[k+1].low = {sat_r[k].low[QUO_W-2:0], 1'b0};
      if (s_trial[k] >= {1'b0, sat_r[k].div}) begin
        sat_nxt[k+1].rem = CHAN_W'(s_trial[k] - {1'b0, sat_r[k].div});
        sat_nxt[k+1].quo = {sat_r[k].quo[QUO_W-2:0], 1'b1};
      end else begin
        sat_nxt[k+1].rem = s_trial[k][CHAN_W-1:0];
        sat_nxt[k+1].quo = {sat_r[k].quo[QUO_W-2:0], 1'b0};
      end
      h_trial[k] = {hue_r[k].rem, 1'b0};
      hue_nxt[k+1].div = hue_r[k].div;
      if (h_trial[k] >= {1'b0, hue_r[k].div}) begin
        hue_nxt[k+1].rem = HDIV_W'(h_trial[k] - {1'b0, hue_r[k].div});
        hue_nxt[k+1].quo = {hue_r[k].quo[QUO_W-2:0], 1'b1};
      end else begin
        hue_nxt[k+1].rem = h_trial[k][HDIV_W-1:0];
        hue_nxt[k+1].quo = {hue_r[k].quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUO_W; k++) begin
        dv_valid_r[k] <= 1'b0;
      end
    end else begin
      dv_valid_r[0] <= s2_valid_r;
      for (int k = 0; k < QUO_W; k++) begin
        dv_valid_r[k+1] <= dv_valid_r[k];
      end
    end
    dv_max_r[0] <= s2_max_r;
    for (int k = 0; k < QUO_W; k++) begin
      dv_max_r[k+1] <= dv_max_r[k];
    end
    for (int k = 0; k <= QUO_W; k++) begin
      sat_r[k] <= sat_nxt[k];
      hue_r[k] <= hue_nxt[k];
    end
  end

  // Output register: drop quotients whose divisor was zero
  logic  out_valid_r, out_undef_r, undef_nxt;
  quo_t  out_hue_r, out_sat_r, out_bright_r;

  assign undef_nxt = (hue_r[QUO_W].div == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[QUO_W];
    end
    out_undef_r  <= undef_nxt;
    out_hue_r    <= undef_nxt ? '0 : hue_r[QUO_W].quo;
    out_sat_r    <= (dv_max_r[QUO_W] == '0) ? '0 : sat_r[QUO_W].quo;
    out_bright_r <= {dv_max_r[QUO_W], dv_max_r[QUO_W]};
  end

  assign out_valid         = out_valid_r;
  assign out_hue           = out_hue_r;
  assign out_saturation    = out_sat_r;
  assign out_brightness    = out_bright_r;
  assign out_hue_undefined = out_undef_r;

  localparam int unsigned LAT = LATENCY;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("result missing after pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching transaction");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hue_undefined |-> out_hue == '0 && out_saturation == '0)
    else $error("undefined hue with nonzero hue or saturation");

  a_black_undef: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brightness == '0 |-> out_hue_undefined)
    else $error("black pixel not flagged undefined");

endmodule

// ===== bench/rgb_to_hsv_converter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top_test
// Self-checking bench for the pipelined RGB to HSV converter.
// ----------------------------------------------------------------------------
// A stimulus table covers gray levels, the primaries, ties for the largest
// channel and the hue wrap. It is followed by random pixels sent under
// several sender pacing phases. Every accepted transaction is predicted,
// from the table for typed rows and in integer arithmetic otherwise, and
// every strobed result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top_test;
  import rgbhsv_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 600;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned TABLE_ROWS    = 20;

  typedef struct packed {
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] brightness;
    logic        hue_undefined;
  } hsv_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  typed;
    hsv_t  hsv;
  } pixel_row_t;

  localparam pixel_row_t PIXEL_TABLE [TABLE_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd0,     16'd0,     1'b1}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     16'd0,     16'd65535, 1'b1}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0,     16'd0,     16'd257,   1'b1}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     16'd0,     16'd32896, 1'b1}},
    '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 16'd65535, 1'b0}},
    '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 16'd65535, 16'd65535, 1'b0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 16'd65535, 16'd65535, 1'b0}},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd1,   8'd1,   8'd0,   1'b0, '0},
    '{8'd255, 8'd254, 8'd254, 1'b0, '0},
    '{8'd254, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd254, 8'd255, 1'b0, '0},
    '{8'd170, 8'd85,  8'd170, 1'b0, '0},
    '{8'd85,  8'd170, 8'd85,  1'b0, '0},
    '{8'd128, 8'd64,  8'd192, 1'b0, '0}
  };

  localparam int unsigned IDLE_PCT [4] = '{0, 73, 24, 0};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  chan_t       in_red = '0;
  chan_t       in_green = '0;
  chan_t       in_blue = '0;
  logic        out_valid;
  logic [15:0] out_hue;
  logic [15:0] out_saturation;
  logic [15:0] out_brightness;
  logic        out_hue_undefined;

  logic        row_typed = 1'b0;
  hsv_t        row_hsv = '0;

  hsv_t        hsv_expected [$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cycle_count = 0;

  rgb_to_hsv_converter_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_hue           (out_hue),
    .out_saturation    (out_saturation),
    .out_brightness    (out_brightness),
    .out_hue_undefined (out_hue_undefined)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic hsv_t hsv_of(input chan_t r, input chan_t g, input chan_t b);
    int   mx;
    int   mn;
    int   delta;
    int   num;
    hsv_t h;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    delta = mx - mn;
    h = '0;
    h.brightness = 16'(mx * 257);
    if (mx > 0) h.saturation = 16'((delta * 65535) / mx);
    if (delta == 0) begin
      h.hue_undefined = 1'b1;
    end else begin
      if (r >= mx) begin
        num = int'(g) - int'(b);
        if (num < 0) num += 6 * delta;
      end else if (g >= mx) begin
        num = 2 * delta + int'(b) - int'(r);
      end else begin
        num = 4 * delta + int'(r) - int'(g);
      end
      h.hue = 16'((num * 65536) / (6 * delta));
    end
    return h;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, hsv_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (hsv_expected.size() == 0) begin
        $display("%0t: unexpected result hue=%0d sat=%0d val=%0d undef=%0b", $time,
                 out_hue, out_saturation, out_brightness, out_hue_undefined);
        mismatches++;
      end else begin
        want = hsv_expected.pop_front();
        results_checked++;
        if (out_hue !== want.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, out_hue);
          mismatches++;
        end
        if (out_saturation !== want.saturation) begin
          $display("%0t: saturation expected %0d actual %0d", $time, want.saturation,
                   out_saturation);
          mismatches++;
        end
        if (out_brightness !== want.brightness) begin
          $display("%0t: brightness expected %0d actual %0d", $time, want.brightness,
                   out_brightness);
          mismatches++;
        end
        if (out_hue_undefined !== want.hue_undefined) begin
          $display("%0t: hue_undefined expected %0b actual %0b", $time, want.hue_undefined,
                   out_hue_undefined);
          mismatches++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      hsv_expected.push_back(row_typed ? row_hsv : hsv_of(in_red, in_green, in_blue));
    end
  end

  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                            input logic typed, input hsv_t hsv, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start     = 1'b1;
    in_red    = r;
    in_green  = g;
    in_blue   = b;
    row_typed = typed;
    row_hsv   = hsv;
    do @(posedge clk); while (busy);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (hsv_expected.size() != 0) @(negedge clk);
  endtask

  initial begin
    chan_t       r;
    chan_t       g;
    chan_t       b;
    int unsigned kind;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int i = 0; i < TABLE_ROWS; i++) begin
      send_pixel(PIXEL_TABLE[i].red, PIXEL_TABLE[i].green, PIXEL_TABLE[i].blue,
                 PIXEL_TABLE[i].typed, PIXEL_TABLE[i].hsv, 0);
    end
    // hold off until the pipeline is empty
    drain_results();
    for (int phase = 0; phase < 4; phase++) begin
      for (int n = 0; n < RANDOM_PIXELS / 4; n++) begin
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
        kind = $urandom_range(0, 9);
        unique case (kind)
          0: begin
            g = r;
            b = r;
          end
          1: g = r;
          2: b = g;
          3: b = r;
          4: begin
            r = 8'd255;
          end
          default: ;
        endcase
        send_pixel(r, g, b, 1'b0, '0, IDLE_PCT[phase]);
      end
      drain_results();
    end
    start = 1'b0;
    drain_results();
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d pixels (table, then random under four pacing phases);", pixels_sent);
    $display("compared %0d results, %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0 && hsv_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
